// File: design/invc_pkg.sv
// Package for the inversion counter: sizes, saturation limits and the token
// type that travels down the row of compare cells. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package invc_pkg;

   // Capacity of one sequence (number of cells in the row)
   localparam int MAX_ITEMS = 256;

   localparam int DATA_W  = 32;
   localparam int CNT_W   = $clog2(MAX_ITEMS);
   localparam int TOTAL_W = 15;
   localparam int FILL_W  = 9;
   localparam int RSP_W   = 32;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
   localparam logic [FILL_W-1:0]  COUNT_MAX = {FILL_W{1'b1}};

   // Item count reported when the row filled up
   localparam logic [FILL_W-1:0] FILL_SAT =
      (MAX_ITEMS > 511) ? COUNT_MAX : FILL_W'(MAX_ITEMS);

   // One item on its way through the row
   typedef struct packed {
      logic                     valid;
      logic                     last;
      logic                     stored;  // item was written into a cell
      logic signed [DATA_W-1:0] key;
      logic [CNT_W-1:0]         count;   // stored values greater than key
   } token_type;

endpackage

`default_nettype wire

// File: design/invc_cell.sv
// One compare cell of the inversion counter row. Holds one stored value,
// compares passing items against it and hands the token on each cycle that
// the row advances. Depends on invc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module invc_cell
   import invc_pkg::*;
(
   input  wire       clock,
   input  wire       reset,
   input  wire       advance,
   input  token_type tok_prev,
   output token_type tok_next
);

   logic                     occ_ff, occ_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic                     valid_ff;
   token_type                tok_ff, tok_in;

   // Compare against the held value, or take the item if the cell is free
   always_comb begin
      tok_in = tok_prev;
      occ_in = occ_ff;
      val_in = val_ff;
      if (tok_prev.valid && !tok_prev.stored) begin
         if (occ_ff) begin
            if (val_ff > tok_prev.key) begin
               tok_in.count = tok_prev.count + CNT_W'(1);
            end
         end else begin
            tok_in.stored = 1'b1;
            occ_in        = 1'b1;
            val_in        = tok_prev.key;
         end
      end
      // last item empties the cell behind it for the next sequence
      if (tok_prev.valid && tok_prev.last) begin
         occ_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else if (advance) begin
         occ_ff   <= occ_in;
         valid_ff <= tok_in.valid;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (advance) begin
         val_ff <= val_in;
         tok_ff <= tok_in;
      end
   end

   // Outgoing token, valid bit from the reset register
   always_comb begin
      tok_next       = tok_ff;
      tok_next.valid = valid_ff;
   end

endmodule

`default_nettype wire

// File: design/invc_tail.sv
// End of the inversion counter row: sums per-item counts into the sequence
// total, counts stored items, and holds the result until transferred.
// Depends on invc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module invc_tail
   import invc_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  token_type         tok_end,
   output logic              advance,
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata
);

   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic [FILL_W-1:0]  rsp_fill_ff, rsp_fill_in;
   logic               rsp_ovf_ff, rsp_ovf_in;
   logic [TOTAL_W:0]   sum;
   logic [TOTAL_W-1:0] total_upd;
   logic [FILL_W-1:0]  fill_upd;
   logic               ovf_upd;

   // Row holds only when a finished result is still waiting
   assign advance = !(tok_end.valid && tok_end.last && rsp_valid_ff && !rsp_tready);

   // Accumulate the item leaving the row
   always_comb begin
      sum       = {1'b0, total_ff} + (TOTAL_W+1)'(tok_end.count);
      total_upd = total_ff;
      fill_upd  = fill_ff;
      ovf_upd   = ovf_ff;
      if (tok_end.stored) begin
         total_upd = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
         if (fill_ff != COUNT_MAX) begin
            fill_upd = fill_ff + FILL_W'(1);
         end
      end else begin
         ovf_upd = 1'b1;
      end

      total_in     = total_ff;
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_total_in = rsp_total_ff;
      rsp_fill_in  = rsp_fill_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (advance && tok_end.valid) begin
         if (tok_end.last) begin
            total_in     = '0;
            fill_in      = '0;
            ovf_in       = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_total_in = total_upd;
            rsp_fill_in  = fill_upd;
            rsp_ovf_in   = ovf_upd;
         end else begin
            total_in = total_upd;
            fill_in  = fill_upd;
            ovf_in   = ovf_upd;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_total_ff <= rsp_total_in;
      rsp_fill_ff  <= rsp_fill_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-TOTAL_W-FILL_W-1){1'b0}}, rsp_ovf_ff, rsp_fill_ff, rsp_total_ff};

endmodule

`default_nettype wire

// File: design/inversion_counter.sv
// Inversion counter. Counts the pairs of a streamed sequence of signed 32-bit
// values where an earlier value is strictly greater than a later one. Each
// item enters a row of MAX_ITEMS cells and moves one cell per cycle while the
// row advances; every occupied cell compares its value with the item and the
// first free cell keeps it. One item is taken every cycle unless the input
// stalls. The result of a sequence is registered in the tail once its last
// item has passed the whole cell row; the input stalls only while a finished
// result has not been transferred and the next sequence's last item reaches
// the end of the row. Values beyond MAX_ITEMS in a sequence are dropped and
// flagged as overflow. Depends on invc_pkg, invc_cell and invc_tail.
`timescale 1ns / 1ps
`default_nettype none

module inversion_counter
   import invc_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                req_tvalid,
   output logic               req_tready,
   input  wire  [DATA_W-1:0]  req_tdata,   // [31:0] value
   input  wire                req_tlast,
   output logic               rsp_tvalid,
   input  wire                rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata    // [14:0] inversions, [23:15] item_count,
                                           // [24] overflow, [31:25] zero
);

   token_type tok [MAX_ITEMS+1];
   logic      advance;

   // New item enters the row
   assign tok[0] = '{valid:  req_tvalid,
                     last:   req_tlast,
                     stored: 1'b0,
                     key:    $signed(req_tdata),
                     count:  '0};

   assign req_tready = advance;

   // Row of compare cells
   for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
      invc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .tok_prev (tok[k]),
         .tok_next (tok[k+1])
      );
   end

   // Totals and result register
   invc_tail u_tail (
      .clock      (clock),
      .reset      (reset),
      .tok_end    (tok[MAX_ITEMS]),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Input only stalls behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without a waiting result");

   // Every result covers at least one stored item
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[23:15] != '0))
      else $error("result with zero items");

   // Overflow only when the row was full
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[24]) |-> (rsp_tdata[23:15] == FILL_SAT))
      else $error("overflow flagged with row not full");

endmodule

`default_nettype wire
